@@ src/tts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the trilinear texture sampler.
// No dependencies; the top, texel pipe and blend refer to this package by scoped names.
package tts_pkg;

	localparam int LVL_MAX = 9;
	localparam int LB_W = 17;
	localparam logic [8:0] DIM_TOP = 9'd256;
	localparam logic [15:0] MANT_ONE = 16'd32768;
	localparam logic [39:0] MAGENTA_ACC = 40'hFF_0000_0000;
	localparam logic [47:0] ROUND_BIAS = 48'h0000_FF00_0000;
	localparam logic [15:0] RECIP_255 = 16'd32896;
	localparam logic [15:0] CH_MAX = 16'd32768;
	localparam logic [22:0] R255 = 23'd255;

	typedef struct packed {
		logic valid;
		logic wr;
		logic pass1;
		logic [3:0] lvl;
		logic [16:0] u;
		logic [16:0] v;
		logic [7:0] x;
		logic [7:0] y;
		logic [31:0] rgba;
	} op_t;

	typedef struct packed {
		logic valid;
		logic pass1;
		logic [3:0][39:0] ch;
	} lvl_res_t;

	function automatic logic [8:0] clamp_dim(input logic [8:0] dim);
		logic [8:0] res;
		if (dim == '0) res = 9'd1;
		else if (dim > DIM_TOP) res = DIM_TOP;
		else res = dim;
		return res;
	endfunction

	function automatic logic [8:0] lvl_dim(input logic [8:0] dim, input logic [3:0] lvl);
		logic [8:0] s;
		s = dim >> lvl;
		return (s == '0) ? 9'd1 : s;
	endfunction

	function automatic logic [7:0] half_up(input logic [8:0] dim);
		logic [9:0] s;
		s = {1'b0, dim} + 10'd1;
		return s[8:1];
	endfunction

	function automatic logic [3:0] top_bit(input logic [15:0] val);
		logic [3:0] pos;
		pos = '0;
		for (int i = 0; i < 16; i++) begin
			if (val[i]) pos = 4'(i);
		end
		return pos;
	endfunction

endpackage

@@ src/trilinear_texture_sampler_unit.sv @@
`timescale 1ns / 1ps
// Trilinear sampler top: config registers, level base table, issue and pipes.
// Throughput: a sample issues its lower then its upper level, one level per cycle
// through the four-bank store, and holds busy while the upper level issues; a
// texel write every cycle while not busy. The result strobe cannot be stalled.
// Reset and every config write hold busy while level bases rebuild.
// Depends on tts_pkg, tts_level_unit, tts_texel_pipe, tts_blend.
module trilinear_texture_sampler_unit #(
	parameter int STORE_DEPTH = 131072
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [3:0] write_level,
	input logic [7:0] texel_x,
	input logic [7:0] texel_y,
	input logic [31:0] texel_rgba,
	input logic [16:0] coord_u,
	input logic [16:0] coord_v,
	input logic [15:0] scale_u,
	input logic [15:0] scale_v,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [8:0] cfg_data,
	output logic strobe,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic [15:0] alpha
);

	localparam logic [1:0] REG_BASE_WIDTH = 2'd0;
	localparam logic [1:0] REG_BASE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

	logic [8:0] base_width_q, base_height_q;
	logic [3:0] level_count_q;
	logic rc_run_q;
	logic [2:0] rc_cnt_q;
	logic [tts_pkg::LB_W-1:0] lbase_q [tts_pkg::LVL_MAX];
	logic pend_q;
	logic [3:0] hold_lvl_q;
	logic [16:0] hold_u_q, hold_v_q;
	logic accept, cfg_wr;
	logic [8:0] wc, hc;
	logic [3:0] nact, rc_next;
	logic [7:0] rc_hw, rc_hh;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = pend_q || rc_run_q;
	assign accept = start && !busy;
	assign wc = tts_pkg::clamp_dim(base_width_q);
	assign hc = tts_pkg::clamp_dim(base_height_q);
	assign nact = (level_count_q < 4'(tts_pkg::LVL_MAX)) ? level_count_q
		: 4'(tts_pkg::LVL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q <= 9'd256;
			base_height_q <= 9'd256;
			level_count_q <= 4'd9;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_BASE_WIDTH: base_width_q <= cfg_data;
				REG_BASE_HEIGHT: base_height_q <= cfg_data;
				REG_LEVEL_COUNT: level_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// rebuild the per-level bank offsets, one level per cycle
	assign rc_next = {1'b0, rc_cnt_q} + 4'd1;
	assign rc_hw = tts_pkg::half_up(tts_pkg::lvl_dim(wc, {1'b0, rc_cnt_q}));
	assign rc_hh = tts_pkg::half_up(tts_pkg::lvl_dim(hc, {1'b0, rc_cnt_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_run_q <= 1'b1;
			rc_cnt_q <= '0;
		end else if (cfg_wr) begin
			rc_run_q <= 1'b1;
			rc_cnt_q <= '0;
		end else if (rc_run_q) begin
			rc_cnt_q <= rc_cnt_q + 3'd1;
			if (rc_cnt_q == 3'd7) rc_run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		lbase_q[0] <= '0;
		if (rc_run_q) begin
			lbase_q[rc_next] <= lbase_q[{1'b0, rc_cnt_q}]
				+ {1'b0, {8'b0, rc_hw} * {8'b0, rc_hh}};
		end
	end

	// level select: integer part from the top set bit of the larger scale
	logic [15:0] scale_max, mant0;
	logic [3:0] top_pos, e_lvl;

	always_comb begin
		scale_max = (scale_u > scale_v) ? scale_u : scale_v;
		top_pos = tts_pkg::top_bit(scale_max);
		if (scale_max[15:8] == '0) begin
			e_lvl = '0;
			mant0 = tts_pkg::MANT_ONE;
		end else begin
			e_lvl = top_pos - 4'd8;
			mant0 = scale_max << (4'd15 - top_pos);
		end
	end

	// issue: a sample's lower level on the accept cycle, upper level on the next; a write issues once
	tts_pkg::op_t op_d, op_s1;

	always_comb begin
		op_d = '0;
		if (pend_q) begin
			op_d.valid = 1'b1;
			op_d.pass1 = 1'b1;
			op_d.lvl = hold_lvl_q;
			op_d.u = hold_u_q;
			op_d.v = hold_v_q;
		end else if (accept) begin
			op_d.valid = 1'b1;
			op_d.wr = !opcode;
			op_d.lvl = opcode ? e_lvl : write_level;
			op_d.u = coord_u;
			op_d.v = coord_v;
			op_d.x = texel_x;
			op_d.y = texel_y;
			op_d.rgba = texel_rgba;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			pend_q <= 1'b0;
		end else begin
			op_s1 <= op_d;
			pend_q <= accept && opcode;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode) begin
			hold_lvl_q <= e_lvl + 4'd1;
			hold_u_q <= coord_u;
			hold_v_q <= coord_v;
		end
	end

	logic [7:0] frac;
	tts_pkg::lvl_res_t res_s5;

	tts_level_unit u_level (
		.clk (clk),
		.mant_in (mant0),
		.frac (frac)
	);

	tts_texel_pipe #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_pipe (
		.clk (clk),
		.arst_n (arst_n),
		.op_s1 (op_s1),
		.wc (wc),
		.hc (hc),
		.nact (nact),
		.lbase (lbase_q),
		.res_s5 (res_s5)
	);

	tts_blend u_blend (
		.clk (clk),
		.arst_n (arst_n),
		.res_s5 (res_s5),
		.frac (frac),
		.strobe (strobe),
		.red (red),
		.green (green),
		.blue (blue),
		.alpha (alpha)
	);

endmodule

@@ src/tts_level_unit.sv @@
`timescale 1ns / 1ps
// Level fraction unit: eight pipelined squaring rounds of the scale mantissa.
// Has no dependencies.
module tts_level_unit (
	input logic clk,
	input logic [15:0] mant_in,
	output logic [7:0] frac
);

	logic [15:0] mant_s [9];
	logic [7:0] frac_s [9];

	always_ff @(posedge clk) begin
		mant_s[0] <= mant_in;
		frac_s[0] <= '0;
	end

	for (genvar r = 1; r < 9; r++) begin : g_round
		logic [31:0] sq;
		logic [16:0] ms;
		always_comb begin
			sq = {16'b0, mant_s[r-1]} * {16'b0, mant_s[r-1]};
			ms = sq[31:15];
		end
		always_ff @(posedge clk) begin
			// mantissa at or above two: emit a one and renormalize
			if (ms[16]) begin
				mant_s[r] <= ms[16:1];
				frac_s[r] <= {frac_s[r-1][6:0], 1'b1};
			end else begin
				mant_s[r] <= ms[15:0];
				frac_s[r] <= {frac_s[r-1][6:0], 1'b0};
			end
		end
	end

	assign frac = frac_s[8];

endmodule

@@ src/tts_texel_pipe.sv @@
`timescale 1ns / 1ps
// Per-level bilinear pipe: coordinate scaling, four-bank texel store, weighted sums.
// Uses tts_pkg types and helpers.
module tts_texel_pipe #(
	parameter int STORE_DEPTH = 131072
) (
	input logic clk,
	input logic arst_n,
	input tts_pkg::op_t op_s1,
	input logic [8:0] wc,
	input logic [8:0] hc,
	input logic [3:0] nact,
	input logic [tts_pkg::LB_W-1:0] lbase [tts_pkg::LVL_MAX],
	output tts_pkg::lvl_res_t res_s5
);

	localparam int BANK_DEPTH = STORE_DEPTH / 4;
	localparam int BANK_AW = $clog2(BANK_DEPTH);

	typedef struct packed {
		logic valid;
		logic wr;
		logic pass1;
		logic act;
		logic [tts_pkg::LB_W-1:0] base;
		logic [8:0] w;
		logic [8:0] h;
		logic [7:0] hw;
		logic [8:0] xi;
		logic [8:0] yi;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [7:0] x;
		logic [7:0] y;
		logic [31:0] rgba;
	} st2_t;

	typedef struct packed {
		logic valid;
		logic wr;
		logic pass1;
		logic act;
		logic [3:0] en;
		logic [3:0][33:0] wt;
		logic [31:0] rgba;
	} st3_t;

	// stage 2: level geometry and scaled coordinates
	st2_t s2_d, s2;
	logic [25:0] xs, ys;
	logic [8:0] lw, lh;
	logic lvl_ok;

	always_comb begin
		lvl_ok = op_s1.lvl < nact;
		lw = tts_pkg::lvl_dim(wc, op_s1.lvl);
		lh = tts_pkg::lvl_dim(hc, op_s1.lvl);
		xs = {9'b0, op_s1.u} * {17'b0, lw} + 26'd32768;
		ys = {9'b0, op_s1.v} * {17'b0, lh} + 26'd32768;
		s2_d.valid = op_s1.valid;
		s2_d.wr = op_s1.wr;
		s2_d.pass1 = op_s1.pass1;
		s2_d.act = lvl_ok;
		s2_d.base = lbase[lvl_ok ? op_s1.lvl : 4'd0];
		s2_d.w = lw;
		s2_d.h = lh;
		s2_d.hw = tts_pkg::half_up(lw);
		// saturate far positions: both neighbours stay outside the level
		s2_d.xi = xs[25] ? 9'h1FF : xs[24:16];
		s2_d.yi = ys[25] ? 9'h1FF : ys[24:16];
		s2_d.fx = xs[15:0];
		s2_d.fy = ys[15:0];
		s2_d.x = op_s1.x;
		s2_d.y = op_s1.y;
		s2_d.rgba = op_s1.rgba;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else begin
			s2 <= s2_d;
		end
	end

	// stage 3: neighbour selection per bank, bank addresses and weights
	st3_t s3_d, s3;
	logic [3:0][BANK_AW-1:0] addr_d, addr_s3;
	logic [8:0] row [2];
	logic [8:0] col [2];
	logic rok [2];
	logic cok [2];
	logic [16:0] wy [2];
	logic [16:0] wx [2];
	logic [15:0] rterm [2];
	logic [17:0] addr18 [4];
	logic wr_ok;

	always_comb begin
		wr_ok = s2.act && ({1'b0, s2.x} < s2.w) && ({1'b0, s2.y} < s2.h);
		for (int p = 0; p < 2; p++) begin
			if (s2.wr) begin
				row[p] = {1'b0, s2.y};
				col[p] = {1'b0, s2.x};
				rok[p] = 1'b0;
				cok[p] = 1'b0;
				wy[p] = '0;
				wx[p] = '0;
			end else begin
				if (s2.yi[0] == p[0]) begin
					row[p] = s2.yi;
					rok[p] = s2.yi < s2.h;
					wy[p] = {1'b0, s2.fy};
				end else begin
					row[p] = s2.yi - 9'd1;
					rok[p] = (s2.yi != '0) && ((s2.yi - 9'd1) < s2.h);
					wy[p] = 17'd65536 - {1'b0, s2.fy};
				end
				if (s2.xi[0] == p[0]) begin
					col[p] = s2.xi;
					cok[p] = s2.xi < s2.w;
					wx[p] = {1'b0, s2.fx};
				end else begin
					col[p] = s2.xi - 9'd1;
					cok[p] = (s2.xi != '0) && ((s2.xi - 9'd1) < s2.w);
					wx[p] = 17'd65536 - {1'b0, s2.fx};
				end
			end
			rterm[p] = {8'b0, row[p][8:1]} * {8'b0, s2.hw};
		end
		for (int b = 0; b < 4; b++) begin
			addr18[b] = {1'b0, s2.base} + {2'b0, rterm[b/2]} + {10'b0, col[b%2][8:1]};
			addr_d[b] = BANK_AW'(addr18[b]);
			if (s2.wr) begin
				s3_d.en[b] = wr_ok && (s2.y[0] == b[1]) && (s2.x[0] == b[0])
					&& (int'(addr18[b]) < BANK_DEPTH);
			end else begin
				s3_d.en[b] = rok[b/2] && cok[b%2] && (int'(addr18[b]) < BANK_DEPTH);
			end
			s3_d.wt[b] = {17'b0, wx[b%2]} * {17'b0, wy[b/2]};
		end
		s3_d.valid = s2.valid;
		s3_d.wr = s2.wr;
		s3_d.pass1 = s2.pass1;
		s3_d.act = s2.act;
		s3_d.rgba = s2.rgba;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3 <= '0;
		end else begin
			s3 <= s3_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_s3 <= addr_d;
	end

	// stage 4: one access per bank; the four neighbours never share a bank
	logic [3:0][31:0] rdata_s4;
	st3_t s4;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0] mem [BANK_DEPTH];
		always_ff @(posedge clk) begin
			if (s3.valid && s3.wr && s3.en[b]) mem[addr_s3[b]] <= s3.rgba;
			rdata_s4[b] <= mem[addr_s3[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4 <= '0;
		end else begin
			s4 <= s3;
		end
	end

	// stage 5: weighted channel sums, magenta for a missing level
	tts_pkg::lvl_res_t res_d;
	logic [41:0] sum;

	always_comb begin
		res_d.valid = s4.valid && !s4.wr;
		res_d.pass1 = s4.pass1;
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			sum = '0;
			for (int b = 0; b < 4; b++) begin
				if (s4.en[b]) sum = sum + {34'b0, rdata_s4[b][8*k +: 8]} * {8'b0, s4.wt[b]};
			end
			if (s4.act) res_d.ch[k] = sum[39:0];
			else res_d.ch[k] = (k == 1) ? 40'd0 : tts_pkg::MAGENTA_ACC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s5 <= '0;
		end else begin
			res_s5 <= res_d;
		end
	end

endmodule

@@ src/tts_blend.sv @@
`timescale 1ns / 1ps
// Level blend and Q1.15 output scaling with a reciprocal divide by 255.
// Uses tts_pkg types and constants.
module tts_blend (
	input logic clk,
	input logic arst_n,
	input tts_pkg::lvl_res_t res_s5,
	input logic [7:0] frac,
	output logic strobe,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic [15:0] alpha
);

	logic [3:0][39:0] c1_q;
	logic [3:0][39:0] lo_s6, lo_s7, lo_s8;
	logic [3:0][39:0] hi_s6, hi_s7, hi_s8;
	logic v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [3:0][47:0] c_s9;
	logic [3:0][22:0] t_s10;
	logic [3:0][15:0] q0_s10;
	logic [3:0][15:0] out_s11;

	// hold the lower level until its partner beat arrives
	always_ff @(posedge clk) begin
		if (res_s5.valid && !res_s5.pass1) c1_q <= res_s5.ch;
		lo_s6 <= c1_q;
		hi_s6 <= res_s5.ch;
		lo_s7 <= lo_s6;
		hi_s7 <= hi_s6;
		lo_s8 <= lo_s7;
		hi_s8 <= hi_s7;
	end

	logic [8:0] w_lo;
	logic [3:0][47:0] c_d;
	logic [3:0][47:0] n_d;
	logic [3:0][38:0] p_d;
	logic [3:0][23:0] qx_d;
	logic [3:0][23:0] r_d;
	logic [3:0][16:0] q_d;
	logic [3:0][15:0] o_d;

	always_comb begin
		w_lo = 9'd256 - {1'b0, frac};
		for (int k = 0; k < 4; k++) begin
			c_d[k] = {8'b0, lo_s8[k]} * {39'b0, w_lo} + {8'b0, hi_s8[k]} * {40'b0, frac};
			n_d[k] = c_s9[k] + tts_pkg::ROUND_BIAS;
			p_d[k] = {16'b0, n_d[k][47:25]} * {23'b0, tts_pkg::RECIP_255};
			qx_d[k] = {q0_s10[k], 8'b0} - {8'b0, q0_s10[k]};
			r_d[k] = {1'b0, t_s10[k]} - qx_d[k];
			// estimate is low by at most one
			q_d[k] = (r_d[k] >= {1'b0, tts_pkg::R255}) ? {1'b0, q0_s10[k]} + 17'd1
				: {1'b0, q0_s10[k]};
			o_d[k] = (q_d[k] > {1'b0, tts_pkg::CH_MAX}) ? tts_pkg::CH_MAX : q_d[k][15:0];
		end
	end

	always_ff @(posedge clk) begin
		c_s9 <= c_d;
		for (int k = 0; k < 4; k++) begin
			t_s10[k] <= n_d[k][47:25];
			q0_s10[k] <= p_d[k][38:23];
		end
		out_s11 <= o_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s6 <= res_s5.valid && res_s5.pass1;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	assign strobe = v_s11;
	assign red = out_s11[0];
	assign green = out_s11[1];
	assign blue = out_s11[2];
	assign alpha = out_s11[3];

endmodule

@@ src/tts_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the trilinear sampler, bound to the top level.
// Depends only on the top level's ports.
module tts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic strobe,
	input logic [15:0] red,
	input logic [15:0] green,
	input logic [15:0] blue,
	input logic [15:0] alpha
);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (red <= 16'd32768) && (green <= 16'd32768)
			&& (blue <= 16'd32768) && (alpha <= 16'd32768))
		else $error("channel above 1.0");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results closer than two cycles");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode) |=> busy)
		else $error("sample did not take a second cycle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode) |-> ##12 strobe)
		else $error("sample result missing at expected cycle");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("config write did not hold off items");

endmodule

bind trilinear_texture_sampler_unit tts_checker u_tts_checker (.*);
